/* rtl/sm4_block_cipher_core_defines.svh */
// Assertion macros shared by the sm4 block cipher checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef SM4_BLOCK_CIPHER_CORE_DEFINES_SVH
`define SM4_BLOCK_CIPHER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is applied
`define SM4_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sm4 core check failed");

// next-cycle implication, disabled while reset is applied
`define SM4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sm4 core check failed");

`endif

/* rtl/sm4_pkg.sv */
// Shared types, action codes, S-box table and round function for the sm4 core.
// No dependencies; used by the core and its checker.
`default_nettype none

package sm4_pkg;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned KEY_AW     = $clog2(NUM_ROUNDS);

    // action codes of an input transaction
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_ENC  = 2'd1;
    localparam logic [1:0] ACT_DEC  = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  key_index;
        logic [31:0] key_word;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } item_t;

    typedef struct packed {
        logic [63:0] out_hi;
        logic [63:0] out_lo;
    } result_t;

    // standard sm4 substitution table
    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // byte-wise s-box followed by the linear transform
    function automatic logic [31:0] t_transform(input logic [31:0] a);
        logic [31:0] b;
        b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
        return b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
    endfunction

endpackage

`default_nettype wire

/* rtl/sm4_block_cipher_core.sv */
// SM4 block cipher core: key store, round sequencer and one shared round unit.
// Depends on sm4_pkg for transaction types, action codes and the round function.
//
// A load transaction (start high while busy is low) writes one round-key word
// and produces no result; busy stays low. An encrypt or decrypt transaction
// raises busy while its rounds run, one sm4 round per cycle through a single
// round unit that takes one key per cycle from the 32-entry key store read
// port. The result appears on result with done high for exactly one cycle,
// in the cycle after the last round; busy is already low in that cycle, so the
// next transaction may be accepted at the edge that ends it. A block
// transaction thus spans its rounds plus the result cycle from accept to the
// next accept. The receiver cannot stall: a result not taken in its done cycle
// is gone. All 32 key slots used by a block must have been loaded since reset.
// Key expansion is not done here.
`default_nettype none

module sm4_block_cipher_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire sm4_pkg::item_t  item,
    output logic                 done,
    output sm4_pkg::result_t     result
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                        state_reg, state_next;
    logic [sm4_pkg::KEY_AW-1:0]    round_reg, round_next;
    logic                          dec_reg, dec_next;
    logic                          done_reg, done_next;
    sm4_pkg::result_t              result_reg, result_next;

    logic [31:0]                   w0_reg, w1_reg, w2_reg, w3_reg;
    logic [31:0]                   key_mem [0:sm4_pkg::NUM_ROUNDS-1];
    logic [31:0]                   key_rd_reg;

    logic                          accept;
    logic                          load_go;
    logic                          block_go;
    logic [sm4_pkg::KEY_AW-1:0]    key_base;
    logic                          key_dec;
    logic [sm4_pkg::KEY_AW-1:0]    key_addr;
    logic [31:0]                   round_new;

    assign accept   = start && (state_reg == ST_IDLE);
    assign load_go  = accept && (item.action == sm4_pkg::ACT_LOAD);
    assign block_go = accept && ((item.action == sm4_pkg::ACT_ENC) ||
                                 (item.action == sm4_pkg::ACT_DEC));

    // key address for the next round; decrypt walks the store backwards
    assign key_base = (state_reg == ST_IDLE) ? '0 : round_reg + 1'b1;
    assign key_dec  = (state_reg == ST_IDLE) ? (item.action == sm4_pkg::ACT_DEC) : dec_reg;
    assign key_addr = key_dec ? ~key_base : key_base;

    // shared round unit
    assign round_new = w0_reg ^ sm4_pkg::t_transform(w1_reg ^ w2_reg ^ w3_reg ^ key_rd_reg);

    // key store: one write port for loads, one registered read port for rounds
    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            key_mem[item.key_index] <= item.key_word;
        end
        key_rd_reg <= key_mem[key_addr];
    end

    // block word shift register
    always_ff @(posedge clk)
    begin
        if (block_go)
        begin
            w0_reg <= item.block_hi[63:32];
            w1_reg <= item.block_hi[31:0];
            w2_reg <= item.block_lo[63:32];
            w3_reg <= item.block_lo[31:0];
        end
        else if (state_reg == ST_RUN)
        begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= w3_reg;
            w3_reg <= round_new;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        dec_next    = dec_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (block_go)
                begin
                    state_next = ST_RUN;
                    round_next = '0;
                    dec_next   = (item.action == sm4_pkg::ACT_DEC);
                end
            end
            ST_RUN:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == sm4_pkg::KEY_AW'(sm4_pkg::NUM_ROUNDS - 1))
                begin
                    // last round: words come out in reversed order
                    state_next         = ST_IDLE;
                    done_next          = 1'b1;
                    result_next.out_hi = {round_new, w3_reg};
                    result_next.out_lo = {w2_reg, w1_reg};
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            round_reg  <= '0;
            dec_reg    <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            dec_reg    <= dec_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg == ST_RUN);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/sm4_block_cipher_core_checker.sv */
// Port-level checks for the sm4 block cipher core, bound to the top level.
// Depends on sm4_pkg and sm4_block_cipher_core_defines.svh.
`default_nettype none

`include "sm4_block_cipher_core_defines.svh"

module sm4_block_cipher_core_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire sm4_pkg::item_t  item,
    input wire logic            done
);

    logic block_accept;

    assign block_accept = start && !busy &&
                          ((item.action == sm4_pkg::ACT_ENC) ||
                           (item.action == sm4_pkg::ACT_DEC));

    // a block transaction occupies the core right away
    `SM4_ASSERT_NEXT(a_block_busy, block_accept, busy)
    // result shows a fixed latency after the block was taken
    `SM4_ASSERT_NOW(a_block_latency, block_accept, ##33 done)
    // each result is a single-cycle strobe
    `SM4_ASSERT_NEXT(a_done_single, done, !done)
    // the core is free again when its result shows
    `SM4_ASSERT_NOW(a_done_idle, done, !busy)

endmodule

bind sm4_block_cipher_core sm4_block_cipher_core_checker u_checker (.*);

`default_nettype wire

/* tb/sm4_block_cipher_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sm4_block_cipher_core: round-key loads, encrypt and decrypt.
// Depends on sm4_pkg for the transaction types and action codes; predicts each block locally.

module sm4_block_cipher_core_test;

    localparam int ROUNDS      = 32;
    localparam int KEY_SLOTS   = 32;
    localparam int RANDOM_ITEMS = 1100;
    localparam int TAIL_ITEMS  = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // action value the block ignores
    localparam logic [1:0] ACT_NONE = 2'd3;

    // sm4 substitution table
    localparam bit [7:0] SUBST [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // transaction waiting to be sent, optionally held until all blocks are back
    typedef struct {
        sm4_pkg::item_t body;
        bit             wait_drain;
    } queued_item_t;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    sm4_pkg::item_t   item  = '0;
    logic             busy;
    logic             done;
    sm4_pkg::result_t result;

    logic [31:0]      key_slots [KEY_SLOTS];
    queued_item_t     items_to_send [$];
    sm4_pkg::result_t cipher_blocks_due [$];

    int mismatch_count = 0;
    int items_taken    = 0;
    int stim_total     = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    bit burst_after_busy = 1'b0;
    bit took;

    sm4_block_cipher_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // nonlinear substitution followed by the linear diffusion step
    function automatic logic [31:0] mix_word(input logic [31:0] a);
        logic [31:0] b;
        b = {SUBST[a[31:24]], SUBST[a[23:16]], SUBST[a[15:8]], SUBST[a[7:0]]};
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // 32 rounds over the current key slots, reverse key order for decryption
    function automatic sm4_pkg::result_t sm4_rounds(input logic [127:0] blk, input bit inverse);
        logic [31:0] w0, w1, w2, w3, rk, nx;
        w0 = blk[127:96];
        w1 = blk[95:64];
        w2 = blk[63:32];
        w3 = blk[31:0];
        for (int r = 0; r < ROUNDS; r++)
        begin
            rk = inverse ? key_slots[ROUNDS - 1 - r] : key_slots[r];
            nx = w0 ^ mix_word(w1 ^ w2 ^ w3 ^ rk);
            w0 = w1;
            w1 = w2;
            w2 = w3;
            w3 = nx;
        end
        return '{out_hi: {w3, w2}, out_lo: {w1, w0}};
    endfunction

    // update the key copy or predict the block for one accepted transaction
    task automatic absorb_item(input sm4_pkg::item_t t);
        case (t.action)
            sm4_pkg::ACT_LOAD:
                key_slots[t.key_index] = t.key_word;
            sm4_pkg::ACT_ENC:
                cipher_blocks_due.push_back(sm4_rounds({t.block_hi, t.block_lo}, 1'b0));
            sm4_pkg::ACT_DEC:
                cipher_blocks_due.push_back(sm4_rounds({t.block_hi, t.block_lo}, 1'b1));
            default:  ;
        endcase
    endtask

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic queue_item(input logic [1:0] act, input logic [4:0] slot,
                              input logic [31:0] word, input logic [63:0] hi,
                              input logic [63:0] lo, input bit drain = 1'b0);
        queued_item_t q;
        q.body       = '{action: act, key_index: slot, key_word: word,
                         block_hi: hi, block_lo: lo};
        q.wait_drain = drain;
        items_to_send.push_back(q);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // driver: presents queued transactions, inserts idle bursts and drain pauses
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
            burst_left = 0;
            burst_after_busy = 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                absorb_item(item);
                items_taken++;
                // random idle burst, none in the tail of the run
                if (items_taken < stim_total - TAIL_ITEMS)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            burst_left = $urandom_range(1, 3);
                            burst_after_busy = (item.action == sm4_pkg::ACT_ENC) ||
                                               (item.action == sm4_pkg::ACT_DEC);
                        end
                        1:
                        begin
                            burst_left = $urandom_range(1, 3);
                            burst_after_busy = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            // a raised start that was not taken stays as it is
            if (!start || took)
            begin
                if (burst_left > 0)
                begin
                    start <= 1'b0;
                    if (!(burst_after_busy && (took || busy)))
                    begin
                        burst_left--;
                        burst_after_busy = 1'b0;
                    end
                end
                else if (items_to_send.size() > 0 &&
                         !(items_to_send[0].wait_drain && cipher_blocks_due.size() > 0))
                begin
                    item  <= items_to_send[0].body;
                    start <= 1'b1;
                    void'(items_to_send.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result strobe with the oldest predicted block
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (cipher_blocks_due.size() == 0)
            begin
                flag_error($sformatf("result with no block pending: %h %h",
                                     result.out_hi, result.out_lo));
            end
            else
            begin
                sm4_pkg::result_t want;
                want = cipher_blocks_due.pop_front();
                if (result.out_hi !== want.out_hi)
                    flag_error($sformatf("out_hi expected %h got %h",
                                         want.out_hi, result.out_hi));
                if (result.out_lo !== want.out_lo)
                    flag_error($sformatf("out_lo expected %h got %h",
                                         want.out_lo, result.out_lo));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        int         pick;
        bit         drain;
        logic [4:0] slot;

        // fill every key slot before any block reads them
        for (int s = 0; s < KEY_SLOTS; s++)
            queue_item(sm4_pkg::ACT_LOAD, s[4:0], $urandom, rand64(), rand64());

        // directed: extreme blocks and keys, ignored fields, ignored action
        queue_item(sm4_pkg::ACT_ENC, 5'd0, 32'd0, 64'd0, 64'd0);
        queue_item(sm4_pkg::ACT_DEC, 5'd0, 32'd0, 64'd0, 64'd0);
        queue_item(sm4_pkg::ACT_ENC, 5'd31, '1, '1, '1);
        queue_item(sm4_pkg::ACT_DEC, 5'd31, '1, '1, '1);
        queue_item(sm4_pkg::ACT_LOAD, 5'd0, 32'd0, '1, '1);
        queue_item(sm4_pkg::ACT_LOAD, 5'd31, 32'hffff_ffff, rand64(), rand64());
        queue_item(sm4_pkg::ACT_ENC, 5'd31, '1, 64'h0123_4567_89ab_cdef,
                   64'hfedc_ba98_7654_3210);
        queue_item(sm4_pkg::ACT_DEC, 5'd31, '1, 64'h0123_4567_89ab_cdef,
                   64'hfedc_ba98_7654_3210);
        queue_item(ACT_NONE, 5'd0, 32'h5a5a_5a5a, rand64(), rand64());
        queue_item(sm4_pkg::ACT_ENC, 5'd0, $urandom, rand64(), rand64());
        queue_item(ACT_NONE, 5'd31, '1, '1, '1);
        queue_item(sm4_pkg::ACT_DEC, 5'd31, $urandom, rand64(), rand64());
        queue_item(sm4_pkg::ACT_LOAD, 5'd15, 32'ha5a5_a5a5, 64'd0, 64'd0);
        queue_item(sm4_pkg::ACT_ENC, 5'd15, 32'd0, rand64(), rand64());
        queue_item(sm4_pkg::ACT_DEC, 5'd0, 32'd0, rand64(), rand64(), 1'b1);
        queue_item(sm4_pkg::ACT_LOAD, 5'd1, $urandom, rand64(), rand64());
        queue_item(sm4_pkg::ACT_LOAD, 5'd30, $urandom, rand64(), rand64());
        queue_item(sm4_pkg::ACT_ENC, 5'd0, 32'd0, 64'haaaa_aaaa_aaaa_aaaa,
                   64'h5555_5555_5555_5555);
        queue_item(sm4_pkg::ACT_DEC, 5'd0, 32'd0, 64'h5555_5555_5555_5555,
                   64'haaaa_aaaa_aaaa_aaaa);

        // random mix, mostly blocks with occasional key updates
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick  = $urandom_range(0, 99);
            drain = (n % 250 == 125);
            slot  = 5'($urandom);
            if (pick < 50)
                queue_item(sm4_pkg::ACT_ENC, slot, $urandom, rand64(), rand64(), drain);
            else if (pick < 82)
                queue_item(sm4_pkg::ACT_DEC, slot, $urandom, rand64(), rand64(), drain);
            else if (pick < 96)
                queue_item(sm4_pkg::ACT_LOAD, slot, $urandom, rand64(), rand64(), drain);
            else
                queue_item(ACT_NONE, slot, $urandom, rand64(), rand64(), drain);
        end
        stim_total = items_to_send.size();

        // hold reset, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken < stim_total)
            @(posedge clk);
        while (cipher_blocks_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && cipher_blocks_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sm4_pkg.sv
rtl/sm4_block_cipher_core.sv
rtl/sm4_block_cipher_core_checker.sv
tb/sm4_block_cipher_core_test.sv
